// ----- rtl/core/fabc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame allocator package
// Shared command, status, configuration and state codes and the request and
// result word types of the frame allocator with bank caches.
// ----------------------------------------------------------------------------
package fabc_pkg;

    // Command codes of a request word.
    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_INIT    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LIMIT  = 2'd1,
        ST_RANGE  = 2'd2,
        ST_DOUBLE = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RANGE_START = 2'd0,
        CFG_FRAME_COUNT = 2'd1,
        CFG_FIRST_FREE  = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // Sequencer states of the allocator.
    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC, S_RF_RD, S_RF_LD, S_RF_SCAN, S_SEARCH, S_POP, S_POP_WAIT,
        S_REL_CHK, S_REL_RD, S_REL_UPD, S_INIT
    } t_state;

    localparam int OID_W = 48;
    localparam int CNT_W = 13;

    // One request word.
    typedef struct packed {
        t_cmd             command;
        logic [3:0]       bank_slot;
        logic             object_type;
        logic [OID_W-1:0] release_oid;
    } t_req;

    // One result word.
    typedef struct packed {
        t_status          status;
        logic [OID_W-1:0] alloc_oid;
    } t_res;

endpackage

// ----- rtl/core/frame_allocator_with_bank_caches.sv -----
// Allocate takes from the own cache; otherwise a refill reads, loads and scans bitmap words,
// moving free frames into the cache, and then a cache search visits up to 2*NUM_BANKS caches.
// Release checks the range, then pushes into the cache or updates the bitmap.
// One word is in flight at a time; busy stays high until its result strobe is issued.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset clears control state, counts and bitmap valid bits.
// ----------------------------------------------------------------------------
// Frame allocator with bank caches
// Bitmap frame allocator with per-bank LIFO caches for two object types,
// driven by a small sequencer over one bitmap port and one cache port.
// ----------------------------------------------------------------------------
module frame_allocator_with_bank_caches #(
    parameter int NUM_FRAMES     = 4096,
    parameter int NUM_BANKS      = 16,
    parameter int CACHE_DEPTH    = 16,
    parameter int OIDS_PER_FRAME = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  fabc_pkg::t_req               i_req,
    output logic                         o_busy,
    output logic                         o_done,
    output fabc_pkg::t_res               o_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [fabc_pkg::OID_W-1:0]   i_cfg_data
);

    localparam int MAP_WORDS   = (NUM_FRAMES + 31) / 32;
    localparam int MW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int NUM_CACHES  = 2 * NUM_BANKS;
    localparam int CW          = $clog2(NUM_CACHES);
    localparam int BW          = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int NW          = $clog2(CACHE_DEPTH + 1);
    localparam int CACHE_WORDS = NUM_CACHES * CACHE_DEPTH;
    localparam int AW          = $clog2(CACHE_WORDS);
    localparam int TW          = $clog2(NUM_FRAMES + 1);
    localparam int XW          = (MW + 6 > 13) ? MW + 6 : 13;
    localparam int OW          = fabc_pkg::OID_W;
    // Frame index from an in-range offset, which is below NUM_FRAMES frames.
    localparam int DX          = $clog2(NUM_FRAMES * OIDS_PER_FRAME);
    localparam int DL          = $clog2(OIDS_PER_FRAME);
    localparam int DIV_SH      = DX + DL;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_SH) + OIDS_PER_FRAME - 1) / OIDS_PER_FRAME;
    localparam int WORD_SPAN   = 32 * OIDS_PER_FRAME;

    fabc_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [OW-1:0] r_start;
    logic [12:0]   r_count, r_first;

    // Control and working registers.
    logic                 r_done, n_done;
    fabc_pkg::t_res       r_res, n_res;
    fabc_pkg::t_req       r_req, n_req;
    logic [BW-1:0]        r_slot, n_slot;
    logic                 r_ctype, n_ctype;
    logic [BW-1:0]        r_cbank, n_cbank;
    logic [BW-1:0]        r_scnt, n_scnt;
    logic                 r_refilled, n_refilled;
    logic [TW-1:0]        r_total, n_total;
    logic [MW-1:0]        r_widx, n_widx;
    logic [31:0]          r_word, n_word;
    logic [OW-1:0]        r_base, n_base;
    logic [OW:0]          r_diff, n_diff;
    logic [XW-1:0]        r_frame, n_frame;

    // Per-cache read index and fill level.
    logic [NW-1:0] r_cnext [NUM_CACHES];
    logic [NW-1:0] r_cfill [NUM_CACHES];

    // Memories.
    logic [31:0]   r_map_mem [MAP_WORDS];
    logic          r_map_v   [MAP_WORDS];
    logic [31:0]   r_map_q;
    logic          r_map_qv;
    logic [OW-1:0] r_cache_mem [CACHE_WORDS];
    logic [OW-1:0] r_cache_q;

    // Memory and cache control.
    logic [MW-1:0] map_raddr, map_waddr;
    logic          map_we;
    logic [31:0]   map_wdata;
    logic [AW-1:0] ca_raddr, ca_waddr;
    logic          ca_we;
    logic [OW-1:0] ca_wdata;
    logic          nx_we, fl_we;
    logic [NW-1:0] nx_val, fl_val;

    // Derived values.
    logic [BW-1:0]   slot_tab [16];
    logic [CW-1:0]   cidx;
    logic [AW-1:0]   cbase;
    logic [NW-1:0]   cur_next, cur_fill;
    logic [XW-1:0]   eff, first_x;
    logic [TW-1:0]   init_total;
    logic [OW-1:0]   span;
    logic [31:0]     init_mask;
    logic [4:0]      low_bit;
    logic [2*DX:0]   prod;
    logic [31:0]     map_word;
    logic [MW-1:0]   rel_widx;

    // Slot reduction table, bank_slot modulo the bank count.
    for (genvar g = 0; g < 16; g++) begin : g_slot
        assign slot_tab[g] = BW'(g % NUM_BANKS);
    end

    // The cache under work: own cache, or the one the search has reached.
    assign cidx     = r_ctype ? (CW'(NUM_BANKS) + CW'(r_cbank)) : CW'(r_cbank);
    assign cbase    = AW'(int'(cidx) * CACHE_DEPTH);
    assign cur_next = r_cnext[cidx];
    assign cur_fill = r_cfill[cidx];

    // Effective frame count and range values.
    assign eff        = (XW'(r_count) > XW'(NUM_FRAMES)) ? XW'(NUM_FRAMES) : XW'(r_count);
    assign first_x    = XW'(r_first);
    assign init_total = (eff > first_x) ? TW'(eff - first_x) : '0;
    assign span       = OW'(eff) * OW'(OIDS_PER_FRAME);
    assign prod       = r_diff[DX-1:0] * DIV_M[DX:0];
    assign map_word   = r_map_qv ? r_map_q : '0;
    assign rel_widx   = MW'(r_frame >> 5);

    // Free bits of the bitmap word being initialized.
    always_comb begin
        logic [XW-1:0] idx;
        for (int k = 0; k < 32; k++) begin
            idx          = (XW'(r_widx) << 5) | XW'(k);
            init_mask[k] = (idx >= first_x) && (idx < eff);
        end
    end

    // Lowest set bit of the working bitmap word.
    always_comb begin
        low_bit = '0;
        for (int k = 31; k >= 0; k--) begin
            if (r_word[k]) begin
                low_bit = 5'(k);
            end
        end
    end

    // Sequencer: next state and datapath controls.
    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_res      = r_res;
        n_req      = r_req;
        n_slot     = r_slot;
        n_ctype    = r_ctype;
        n_cbank    = r_cbank;
        n_scnt     = r_scnt;
        n_refilled = r_refilled;
        n_total    = r_total;
        n_widx     = r_widx;
        n_word     = r_word;
        n_base     = r_base;
        n_diff     = r_diff;
        n_frame    = r_frame;
        map_raddr  = r_widx;
        map_we     = 1'b0;
        map_waddr  = r_widx;
        map_wdata  = r_word;
        ca_raddr   = cbase + AW'(cur_next);
        ca_we      = 1'b0;
        ca_waddr   = cbase + AW'(cur_fill);
        ca_wdata   = r_req.release_oid;
        nx_we      = 1'b0;
        nx_val     = cur_next;
        fl_we      = 1'b0;
        fl_val     = cur_fill;

        unique case (r_state)
            fabc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req      = i_req;
                    n_slot     = slot_tab[i_req.bank_slot];
                    n_ctype    = i_req.object_type;
                    n_cbank    = slot_tab[i_req.bank_slot];
                    n_diff     = {1'b0, i_req.release_oid} - {1'b0, r_start};
                    n_widx     = '0;
                    n_refilled = 1'b0;
                    unique case (i_req.command)
                        fabc_pkg::CMD_ALLOC:   n_state = fabc_pkg::S_ALLOC;
                        fabc_pkg::CMD_RELEASE: n_state = fabc_pkg::S_REL_CHK;
                        fabc_pkg::CMD_INIT: begin
                            n_total = init_total;
                            n_state = fabc_pkg::S_INIT;
                        end
                        fabc_pkg::CMD_NOP: begin
                            n_done          = 1'b1;
                            n_res.status    = fabc_pkg::ST_OK;
                            n_res.alloc_oid = '0;
                        end
                        default: n_state = fabc_pkg::S_IDLE;
                    endcase
                end
            end

            // Own cache first, then one refill, then the search.
            fabc_pkg::S_ALLOC: begin
                if (cur_next != cur_fill) begin
                    n_state = fabc_pkg::S_POP;
                end else if (!r_refilled && (r_total != '0)) begin
                    nx_we      = 1'b1;
                    nx_val     = '0;
                    fl_we      = 1'b1;
                    fl_val     = '0;
                    n_refilled = 1'b1;
                    n_widx     = '0;
                    n_state    = fabc_pkg::S_RF_RD;
                end else begin
                    n_scnt  = '0;
                    n_state = fabc_pkg::S_SEARCH;
                end
            end

            fabc_pkg::S_RF_RD: begin
                map_raddr = r_widx;
                n_state   = fabc_pkg::S_RF_LD;
            end

            fabc_pkg::S_RF_LD: begin
                n_word  = map_word;
                n_base  = r_start + OW'(r_widx) * OW'(WORD_SPAN);
                n_state = fabc_pkg::S_RF_SCAN;
            end

            // Move one free frame a cycle into the cache, then write the word back.
            fabc_pkg::S_RF_SCAN: begin
                if ((r_word != '0) && (cur_fill < NW'(CACHE_DEPTH))) begin
                    ca_we    = 1'b1;
                    ca_waddr = cbase + AW'(cur_fill);
                    ca_wdata = r_base + OW'(low_bit) * OW'(OIDS_PER_FRAME);
                    fl_we    = 1'b1;
                    fl_val   = cur_fill + NW'(1);
                    n_word   = r_word & ~(32'd1 << low_bit);
                    n_total  = r_total - TW'(1);
                end else begin
                    map_we    = 1'b1;
                    map_waddr = r_widx;
                    map_wdata = r_word;
                    if ((cur_fill == NW'(CACHE_DEPTH)) || (r_total == '0) ||
                        (r_widx == MW'(MAP_WORDS - 1))) begin
                        n_state = fabc_pkg::S_ALLOC;
                    end else begin
                        n_widx  = r_widx + MW'(1);
                        n_state = fabc_pkg::S_RF_RD;
                    end
                end
            end

            // Round-robin over the caches of one type, then of the other.
            fabc_pkg::S_SEARCH: begin
                if (cur_next != cur_fill) begin
                    n_state = fabc_pkg::S_POP;
                end else if (r_scnt == BW'(NUM_BANKS - 1)) begin
                    if (r_ctype == r_req.object_type) begin
                        n_ctype = ~r_ctype;
                        n_cbank = r_slot;
                        n_scnt  = '0;
                    end else begin
                        n_done          = 1'b1;
                        n_res.status    = fabc_pkg::ST_LIMIT;
                        n_res.alloc_oid = '0;
                        n_state         = fabc_pkg::S_IDLE;
                    end
                end else begin
                    n_scnt  = r_scnt + BW'(1);
                    n_cbank = (r_cbank == BW'(NUM_BANKS - 1)) ? '0 : r_cbank + BW'(1);
                end
            end

            fabc_pkg::S_POP: begin
                ca_raddr = cbase + AW'(cur_next);
                nx_we    = 1'b1;
                nx_val   = cur_next + NW'(1);
                n_state  = fabc_pkg::S_POP_WAIT;
            end

            fabc_pkg::S_POP_WAIT: begin
                n_done          = 1'b1;
                n_res.status    = fabc_pkg::ST_OK;
                n_res.alloc_oid = r_cache_q;
                n_state         = fabc_pkg::S_IDLE;
            end

            // Range test, then push into the cache or compute the frame index.
            fabc_pkg::S_REL_CHK: begin
                if (r_diff[OW] || (r_diff[OW-1:0] >= span)) begin
                    n_done          = 1'b1;
                    n_res.status    = fabc_pkg::ST_RANGE;
                    n_res.alloc_oid = '0;
                    n_state         = fabc_pkg::S_IDLE;
                end else if (cur_next != '0) begin
                    nx_we           = 1'b1;
                    nx_val          = cur_next - NW'(1);
                    ca_we           = 1'b1;
                    ca_waddr        = cbase + AW'(cur_next - NW'(1));
                    ca_wdata        = r_req.release_oid;
                    n_done          = 1'b1;
                    n_res.status    = fabc_pkg::ST_OK;
                    n_res.alloc_oid = '0;
                    n_state         = fabc_pkg::S_IDLE;
                end else begin
                    n_frame = XW'(prod >> DIV_SH);
                    n_state = fabc_pkg::S_REL_RD;
                end
            end

            fabc_pkg::S_REL_RD: begin
                map_raddr = rel_widx;
                n_state   = fabc_pkg::S_REL_UPD;
            end

            // Set the frame's bit unless it is already free.
            fabc_pkg::S_REL_UPD: begin
                n_done          = 1'b1;
                n_res.alloc_oid = '0;
                n_state         = fabc_pkg::S_IDLE;
                if (map_word[r_frame[4:0]]) begin
                    n_res.status = fabc_pkg::ST_DOUBLE;
                end else begin
                    map_we       = 1'b1;
                    map_waddr    = rel_widx;
                    map_wdata    = map_word | (32'd1 << r_frame[4:0]);
                    n_total      = r_total + TW'(1);
                    n_res.status = fabc_pkg::ST_OK;
                end
            end

            // Rewrite the bitmap one word a cycle.
            fabc_pkg::S_INIT: begin
                map_we    = 1'b1;
                map_waddr = r_widx;
                map_wdata = init_mask;
                if (r_widx == MW'(MAP_WORDS - 1)) begin
                    n_done          = 1'b1;
                    n_res.status    = fabc_pkg::ST_OK;
                    n_res.alloc_oid = '0;
                    n_state         = fabc_pkg::S_IDLE;
                end else begin
                    n_widx = r_widx + MW'(1);
                end
            end

            default: n_state = fabc_pkg::S_IDLE;
        endcase
    end

    // Control state, counts and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fabc_pkg::S_IDLE;
            r_done  <= 1'b0;
            r_total <= '0;
            r_start <= '0;
            r_count <= '0;
            r_first <= '0;
            for (int c = 0; c < NUM_CACHES; c++) begin
                r_cnext[c] <= '0;
                r_cfill[c] <= '0;
            end
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map_v[w] <= 1'b0;
            end
            r_map_qv <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_total  <= n_total;
            r_map_qv <= r_map_v[map_raddr];
            if (nx_we) begin
                r_cnext[cidx] <= nx_val;
            end
            if (fl_we) begin
                r_cfill[cidx] <= fl_val;
            end
            if (map_we) begin
                r_map_v[map_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == fabc_pkg::CFG_RANGE_START) begin
                    r_start <= i_cfg_data;
                end else if (i_cfg_index == fabc_pkg::CFG_FRAME_COUNT) begin
                    r_count <= i_cfg_data[12:0];
                end else if (i_cfg_index == fabc_pkg::CFG_FIRST_FREE) begin
                    r_first <= i_cfg_data[12:0];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_req      <= n_req;
        r_slot     <= n_slot;
        r_ctype    <= n_ctype;
        r_cbank    <= n_cbank;
        r_scnt     <= n_scnt;
        r_refilled <= n_refilled;
        r_widx     <= n_widx;
        r_word     <= n_word;
        r_base     <= n_base;
        r_diff     <= n_diff;
        r_frame    <= n_frame;
    end

    // Bitmap memory, registered read.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        r_map_q <= r_map_mem[map_raddr];
    end

    // Cache entry memory, registered read.
    always_ff @(posedge i_clk) begin
        if (ca_we) begin
            r_cache_mem[ca_waddr] <= ca_wdata;
        end
        r_cache_q <= r_cache_mem[ca_raddr];
    end

    assign o_busy      = (r_state != fabc_pkg::S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- test/frame_allocator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator checker
// Watches the request, result and register channels of the frame allocator,
// keeps its own copy of the bitmap, the bank caches and the registers,
// predicts the result word of every accepted request and compares each
// result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_allocator_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  fabc_pkg::t_req             i_req,
    input  logic                       i_done,
    input  fabc_pkg::t_res             i_res,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [fabc_pkg::OID_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int FRAMES   = 4096;
    localparam int BANKS    = 16;
    localparam int DEPTH    = 16;
    localparam int PER_FRM  = 256;
    localparam int OID_W    = fabc_pkg::OID_W;
    localparam int CNT_W    = fabc_pkg::CNT_W;

    // Register copies.
    logic [OID_W-1:0] range_base;
    logic [CNT_W-1:0] frames_cfg;
    logic [CNT_W-1:0] first_free;

    // Allocator state copies.
    bit [FRAMES-1:0]  free_bits;
    int               free_total;
    logic [OID_W-1:0] cache_mem [2*BANKS][DEPTH];
    int               rd_ptr [2*BANKS];
    int               fill_lvl [2*BANKS];

    fabc_pkg::t_res   result_fifo [$];
    int               fails;

    function automatic int usable_frames();
        return (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    endfunction

    // Refill one cache with the lowest free frames in ascending order.
    function automatic bit refill_cache(int c);
        if (free_total == 0) return 1'b0;
        rd_ptr[c]   = 0;
        fill_lvl[c] = 0;
        for (int f = 0; f < FRAMES && fill_lvl[c] < DEPTH; f++) begin
            if (free_bits[f]) begin
                cache_mem[c][fill_lvl[c]] = range_base + OID_W'(f * PER_FRM);
                fill_lvl[c]++;
                free_bits[f] = 1'b0;
                free_total--;
            end
        end
        return fill_lvl[c] != 0;
    endfunction

    function automatic logic [OID_W-1:0] pop_cache(int c);
        logic [OID_W-1:0] v;
        v = cache_mem[c][rd_ptr[c]];
        rd_ptr[c]++;
        return v;
    endfunction

    // Round-robin steal from any cache of one type, starting at the slot.
    function automatic bit steal_frame(int kind, int slot, output logic [OID_W-1:0] oid);
        int c;
        oid = '0;
        for (int i = 0; i < BANKS; i++) begin
            c = kind * BANKS + (i + slot) % BANKS;
            if (rd_ptr[c] != fill_lvl[c]) begin
                oid = pop_cache(c);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the result word of one request and update the state copy.
    function automatic fabc_pkg::t_res allocate_or_free(fabc_pkg::t_req r);
        fabc_pkg::t_res   e;
        int               slot, kind, own, fidx;
        logic [63:0]      span, rel, base;
        logic [OID_W-1:0] got;
        e.status    = fabc_pkg::ST_OK;
        e.alloc_oid = '0;
        slot = int'(r.bank_slot) % BANKS;
        kind = int'(r.object_type);
        own  = kind * BANKS + slot;
        case (r.command)
            fabc_pkg::CMD_ALLOC: begin
                if (rd_ptr[own] != fill_lvl[own] || refill_cache(own)) begin
                    e.alloc_oid = pop_cache(own);
                end else if (steal_frame(kind, slot, got)) begin
                    e.alloc_oid = got;
                end else if (steal_frame(kind ^ 1, slot, got)) begin
                    e.alloc_oid = got;
                end else begin
                    e.status = fabc_pkg::ST_LIMIT;
                end
            end
            fabc_pkg::CMD_RELEASE: begin
                span = 64'(usable_frames()) * PER_FRM;
                rel  = 64'(r.release_oid);
                base = 64'(range_base);
                if (rel < base || rel - base >= span) begin
                    e.status = fabc_pkg::ST_RANGE;
                end else if (rd_ptr[own] > 0) begin
                    // Pushed back into its own cache, no double-free check.
                    rd_ptr[own]--;
                    cache_mem[own][rd_ptr[own]] = r.release_oid;
                end else begin
                    fidx = int'((rel - base) / PER_FRM);
                    if (fidx >= FRAMES || free_bits[fidx]) begin
                        e.status = fabc_pkg::ST_DOUBLE;
                    end else begin
                        free_bits[fidx] = 1'b1;
                        free_total++;
                    end
                end
            end
            fabc_pkg::CMD_INIT: begin
                free_bits  = '0;
                free_total = 0;
                for (int f = int'(first_free); f < usable_frames(); f++) begin
                    free_bits[f] = 1'b1;
                    free_total++;
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    // Watch all channels at each clock edge.
    always @(posedge i_clk) begin
        fabc_pkg::t_res exp_word;
        if (!i_rst_n) begin
            range_base = '0;
            frames_cfg = '0;
            first_free = '0;
            free_bits  = '0;
            free_total = 0;
            for (int c = 0; c < 2*BANKS; c++) begin
                rd_ptr[c]   = 0;
                fill_lvl[c] = 0;
            end
            result_fifo.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (fabc_pkg::t_cfg_idx'(i_cfg_index))
                    fabc_pkg::CFG_RANGE_START: range_base = i_cfg_data;
                    fabc_pkg::CFG_FRAME_COUNT: frames_cfg = i_cfg_data[CNT_W-1:0];
                    fabc_pkg::CFG_FIRST_FREE:  first_free = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (result_fifo.size() == 0) begin
                    $error("result word with no request pending");
                    fails++;
                end else begin
                    exp_word = result_fifo.pop_front();
                    if (i_res.status !== exp_word.status) begin
                        $error("status: expected %0d, got %0d", exp_word.status, i_res.status);
                        fails++;
                    end
                    if (i_res.alloc_oid !== exp_word.alloc_oid) begin
                        $error("alloc_oid: expected %h, got %h",
                               exp_word.alloc_oid, i_res.alloc_oid);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                result_fifo.push_back(allocate_or_free(i_req));
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_fifo.size();
    end

endmodule

// ----- test/frame_allocator_with_bank_caches_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator testbench
// Drives register settings and request words into the frame allocator: a
// short directed run of edge cases, then random phases of allocate, release,
// initialize and no-op words with random gaps. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module frame_allocator_with_bank_caches_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_WORDS = 120;
    localparam int OID_W       = fabc_pkg::OID_W;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    fabc_pkg::t_req   i_req;
    logic             o_busy;
    logic             o_done;
    fabc_pkg::t_res   o_res;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [OID_W-1:0] i_cfg_data;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;

    // Copies of the current settings for building release words.
    logic [OID_W-1:0] cur_base;
    int               cur_frames;

    frame_allocator_with_bank_caches u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    frame_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Write one register word and wait for it to be taken.
    task automatic write_reg(fabc_pkg::t_cfg_idx idx, logic [OID_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Issue one request word; a zero gap keeps start high for the next one.
    task automatic issue_word(fabc_pkg::t_req r, int gap);
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off requests until every result word has come back.
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic fabc_pkg::t_req make_word(fabc_pkg::t_cmd cmd, int slot, int kind,
                                                 logic [OID_W-1:0] oid);
        fabc_pkg::t_req r;
        r.command     = cmd;
        r.bank_slot   = 4'(slot);
        r.object_type = 1'(kind);
        r.release_oid = oid;
        return r;
    endfunction

    // Random identifier across the whole identifier space.
    function automatic logic [OID_W-1:0] rand_oid();
        return OID_W'({$urandom(), $urandom()});
    endfunction

    // Release identifier: mostly frames of the range, some unaligned or outside.
    function automatic logic [OID_W-1:0] pick_release_oid();
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = (cur_frames > 4096) ? 4096 : cur_frames;
        if (top > 0 && r < 65)
            return cur_base + OID_W'($urandom_range(0, top - 1) * 256);
        if (top > 0 && r < 80)
            return cur_base + OID_W'($urandom_range(0, top * 256 - 1));
        if (r < 88) return cur_base - 1;
        if (r < 94) return cur_base + OID_W'(top * 256);
        return rand_oid();
    endfunction

    // Load a setting, then one initialize word.
    task automatic load_setting(logic [OID_W-1:0] base, int frames, int first);
        write_reg(fabc_pkg::CFG_RANGE_START, base);
        write_reg(fabc_pkg::CFG_FRAME_COUNT, OID_W'(frames));
        write_reg(fabc_pkg::CFG_FIRST_FREE, OID_W'(first));
        cur_base   = base;
        cur_frames = frames;
        issue_word(make_word(fabc_pkg::CMD_INIT, $urandom_range(0, 15), $urandom_range(0, 1),
                             rand_oid()), pick_gap());
    endtask

    // One phase of random request words.
    task automatic random_phase(int words);
        int             r;
        int             gap;
        bit             no_idle;
        fabc_pkg::t_req w;
        for (int n = 0; n < words; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            w = make_word(fabc_pkg::CMD_ALLOC, $urandom_range(0, 15), $urandom_range(0, 1),
                          rand_oid());
            if (r >= 50 && r < 88) begin
                w.command     = fabc_pkg::CMD_RELEASE;
                w.release_oid = pick_release_oid();
            end else if (r >= 88 && r < 94) begin
                w.command = fabc_pkg::CMD_INIT;
            end else if (r >= 94) begin
                w.command = fabc_pkg::CMD_NOP;
            end
            gap = no_idle ? 0 : pick_gap();
            issue_word(w, gap);
        end
        wait_drained();
    endtask

    // Stimulus and verdict.
    initial begin
        logic [OID_W-1:0] base;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= fabc_pkg::CFG_RANGE_START;
        i_cfg_data  <= '0;
        cur_base    = '0;
        cur_frames  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small range, refill, push back, range and double-free cases.
        write_reg(fabc_pkg::CFG_UNUSED, rand_oid());
        base = 48'h0000_0000_1000;
        load_setting(base, 64, 2);
        issue_word(make_word(fabc_pkg::CMD_ALLOC, 0, 0, '0), 0);
        issue_word(make_word(fabc_pkg::CMD_ALLOC, 0, 0, '1), 1);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 0, 0, base + 48'h200), 0);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 0, 0, base - 1), 2);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 3, 1, base + 48'h4000), 0);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 7, 0, '1), 0);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 5, 1, base + 48'h3F00), 0);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 5, 1, base + 48'h3F00), 3);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 9, 1, base + 48'h3E7F), 0);
        issue_word(make_word(fabc_pkg::CMD_RELEASE, 9, 1, base + 48'h0100), 0);
        issue_word(make_word(fabc_pkg::CMD_NOP, 15, 1, '1), 0);
        issue_word(make_word(fabc_pkg::CMD_ALLOC, 15, 1, '1), 0);
        for (int i = 0; i < 6; i++)
            issue_word(make_word(fabc_pkg::CMD_ALLOC, i * 3, i % 2, '0), 0);
        issue_word(make_word(fabc_pkg::CMD_INIT, 15, 0, '0), 0);
        wait_drained();
        random_phase(PHASE_WORDS);

        // Range that wraps the identifier space.
        load_setting(48'hFFFF_FFFF_F000, 40, 0);
        random_phase(PHASE_WORDS);

        // Count above the frame total, free frames only at the top.
        load_setting(rand_oid(), 8191, 4000);
        random_phase(PHASE_WORDS);

        // Nothing free at all.
        load_setting('0, 0, 0);
        random_phase(60);

        // Largest base and first free frame past the range.
        load_setting('1, 4096, 4096);
        random_phase(60);

        // Full range, everything free.
        load_setting(rand_oid(), 4096, 0);
        random_phase(PHASE_WORDS);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- frame_allocator_with_bank_caches.f -----
rtl/core/fabc_pkg.sv
rtl/core/frame_allocator_with_bank_caches.sv
test/frame_allocator_checker.sv
test/frame_allocator_with_bank_caches_tb.sv
